// ----- hdl/fpw_pkg.sv -----
package fpw_pkg;

  // Table store geometry. The depth must be a power of two of at least 512 words.
  localparam int TABLE_WORDS = 4096;
  localparam int IDX_W       = $clog2(TABLE_WORDS);

  // Field widths.
  localparam int OP_W    = 2;
  localparam int VA_W    = 64;
  localparam int WIDX_W  = 12;
  localparam int WORD_W  = 64;
  localparam int PA_W    = 64;
  localparam int ROOT_W  = 52;
  localparam int VPN_W   = 9;

  // Entry bit positions.
  localparam int BIT_PRESENT = 0;
  localparam int BIT_HUGE    = 7;

  // Shift of the table index in the virtual address for each level.
  localparam int SHIFT_L4 = 39;
  localparam int SHIFT_L3 = 30;
  localparam int SHIFT_L2 = 21;
  localparam int SHIFT_L1 = 12;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 2'd0,
    OP_TRANSLATE = 2'd1,
    OP_UNMAP     = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_CK4,
    ST_CK3,
    ST_CK2,
    ST_CK1,
    ST_DONE
  } state_t;

  // Table level whose slot address the datapath computes.
  typedef enum logic [1:0] {
    LVL4,
    LVL3,
    LVL2,
    LVL1
  } lvl_t;

  // Source of a table store write.
  typedef enum logic [1:0] {
    WR_CLEAR,
    WR_ITEM,
    WR_SLOT,
    WR_NEXT
  } wr_sel_t;

  // Kind of result captured at the end of a walk.
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_FAULT,
    RES_1G,
    RES_2M,
    RES_4K
  } res_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     rd_en;
    lvl_t     lvl;
    logic     mem_wr;
    wr_sel_t  wr_sel;
    logic     clr_inc;
    logic     set_res;
    res_sel_t res_sel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic present;
    logic huge;
    logic clr_last;
  } status_t;

  // Store word holding entry vpn of the table at physical address taddr.
  function automatic logic [IDX_W-1:0] slot_idx(input logic [ROOT_W-1:0] taddr,
                                                input logic [VPN_W-1:0]  vpn);
    logic [ROOT_W-4:0] words;
    words = {taddr[ROOT_W-1:12], {VPN_W{1'b0}}} + (ROOT_W-3)'(vpn);
    return words[IDX_W-1:0];
  endfunction

endpackage

// ----- hdl/fpw_in_if.sv -----
interface fpw_in_if;
  import fpw_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [VA_W-1:0]     virtual_address;
  logic [WIDX_W-1:0]   word_index;
  logic [WORD_W-1:0]   word_value;

  modport source (output valid, output op, output virtual_address, output word_index,
                  output word_value, input ready);
  modport sink (input valid, input op, input virtual_address, input word_index,
                input word_value, output ready);
endinterface

// ----- hdl/fpw_out_if.sv -----
interface fpw_out_if;
  import fpw_pkg::*;

  logic            valid;
  logic            ready;
  logic [PA_W-1:0] physical_address;
  logic            fault;

  modport source (output valid, output physical_address, output fault, input ready);
  modport sink (input valid, input physical_address, input fault, output ready);
endinterface

// ----- hdl/fpw_cfg_if.sv -----
interface fpw_cfg_if;
  import fpw_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] root_table_address;

  modport source (output valid, output root_table_address, input ready);
  modport sink (input valid, input root_table_address, output ready);
endinterface

// ----- hdl/fpw_ram.sv -----
module fpw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/fpw_ctrl.sv -----
module fpw_ctrl
  import fpw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  input  status_t status,
  output cmd_t    cmd,
  output state_t  state
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status.op == OP_TRANSLATE || status.op == OP_UNMAP) state_nxt = ST_CK4;
        else state_nxt = ST_DONE;
      end
      ST_CK4: begin
        state_nxt = status.present ? ST_CK3 : ST_DONE;
      end
      ST_CK3: begin
        state_nxt = (status.present && !status.huge) ? ST_CK2 : ST_DONE;
      end
      ST_CK2: begin
        if (status.present && !status.huge && status.op != OP_UNMAP) state_nxt = ST_CK1;
        else state_nxt = ST_DONE;
      end
      ST_CK1: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '{latch_in: 1'b0, rd_en: 1'b0, lvl: LVL4, mem_wr: 1'b0, wr_sel: WR_CLEAR,
            clr_inc: 1'b0, set_res: 1'b0, res_sel: RES_ZERO, load_out: 1'b0};
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.mem_wr  = 1'b1;
        cmd.wr_sel  = WR_CLEAR;
        cmd.clr_inc = 1'b1;
      end
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      ST_DISPATCH: begin
        cmd.set_res = 1'b1;
        cmd.res_sel = RES_ZERO;
        if (status.op == OP_WRITE) begin
          cmd.mem_wr = 1'b1;
          cmd.wr_sel = WR_ITEM;
        end else if (status.op == OP_TRANSLATE || status.op == OP_UNMAP) begin
          cmd.set_res = 1'b0;
          cmd.rd_en   = 1'b1;
          cmd.lvl     = LVL4;
        end
      end
      ST_CK4: begin
        cmd.lvl = LVL3;
        if (!status.present) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_FAULT;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_CK3: begin
        cmd.lvl = LVL2;
        if (!status.present) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_FAULT;
        end else if (status.huge) begin
          cmd.set_res = 1'b1;
          if (status.op == OP_TRANSLATE) begin
            cmd.res_sel = RES_1G;
          end else begin
            cmd.res_sel = RES_ZERO;
            cmd.mem_wr  = 1'b1;
            cmd.wr_sel  = WR_SLOT;
          end
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_CK2: begin
        cmd.lvl = LVL1;
        if (!status.present) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_FAULT;
        end else if (status.huge) begin
          cmd.set_res = 1'b1;
          if (status.op == OP_TRANSLATE) begin
            cmd.res_sel = RES_2M;
          end else begin
            cmd.res_sel = RES_ZERO;
            cmd.mem_wr  = 1'b1;
            cmd.wr_sel  = WR_SLOT;
          end
        end else if (status.op == OP_UNMAP) begin
          // A page table entry is cleared without a presence check.
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_ZERO;
          cmd.mem_wr  = 1'b1;
          cmd.wr_sel  = WR_NEXT;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_CK1: begin
        cmd.set_res = 1'b1;
        cmd.res_sel = status.present ? RES_4K : RES_FAULT;
      end
      ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd.latch_in = 1'b0;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;
  assign state     = state_r;

endmodule

// ----- hdl/fpw_datapath.sv -----
module fpw_datapath
  import fpw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [OP_W-1:0]     in_op,
  input  logic [VA_W-1:0]     in_virtual_address,
  input  logic [WIDX_W-1:0]   in_word_index,
  input  logic [WORD_W-1:0]   in_word_value,
  input  logic                cfg_we,
  input  logic [ROOT_W-1:0]   cfg_root_table_address,
  output logic [PA_W-1:0]     out_physical_address,
  output logic                out_fault
);

  logic [ROOT_W-1:0] root_r;
  op_t               op_r;
  logic [VA_W-1:0]   va_r;
  logic [IDX_W-1:0]  widx_r;
  logic [WORD_W-1:0] wval_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  logic [IDX_W-1:0]  slot_r;
  logic [PA_W-1:0]   res_pa_r;
  logic              res_fault_r;
  logic [PA_W-1:0]   out_pa_r;
  logic              out_fault_r;

  logic [WORD_W-1:0] rdata;
  logic [ROOT_W-1:0] base;
  logic [VPN_W-1:0]  vpn;
  logic [IDX_W-1:0]  cur_slot;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic [PA_W-1:0]   res_pa;
  logic              res_fault;

  // Root register, written by the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_we) begin
      root_r <= cfg_root_table_address;
    end
  end

  // Clear pointer for the sweep after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_inc) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_NONE;
    end else if (cmd.latch_in) begin
      op_r <= op_t'(in_op);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      va_r   <= in_virtual_address;
      widx_r <= IDX_W'(in_word_index);
      wval_r <= in_word_value;
    end
  end

  // Slot address of the table at the current level.
  always_comb begin
    base = rdata[ROOT_W-1:0];
    vpn  = va_r[SHIFT_L1 +: VPN_W];
    case (cmd.lvl)
      LVL4: begin
        base = root_r;
        vpn  = va_r[SHIFT_L4 +: VPN_W];
      end
      LVL3: vpn = va_r[SHIFT_L3 +: VPN_W];
      LVL2: vpn = va_r[SHIFT_L2 +: VPN_W];
      LVL1: vpn = va_r[SHIFT_L1 +: VPN_W];
      default: vpn = va_r[SHIFT_L1 +: VPN_W];
    endcase
    cur_slot = slot_idx(base, vpn);
  end

  // The slot of the last read is kept for clearing a huge entry.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      slot_r <= cur_slot;
    end
  end

  // Write port selection.
  always_comb begin
    wdata = '0;
    case (cmd.wr_sel)
      WR_CLEAR: waddr = clr_cnt_r;
      WR_ITEM: begin
        waddr = widx_r;
        wdata = wval_r;
      end
      WR_SLOT: waddr = slot_r;
      WR_NEXT: waddr = cur_slot;
      default: waddr = clr_cnt_r;
    endcase
  end

  fpw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.mem_wr),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (cur_slot),
    .rdata (rdata)
  );

  // Result formation from the entry just read.
  always_comb begin
    res_pa    = '0;
    res_fault = 1'b0;
    case (cmd.res_sel)
      RES_ZERO: res_pa = '0;
      RES_FAULT: begin
        res_pa    = '1;
        res_fault = 1'b1;
      end
      RES_1G: res_pa = {12'b0, rdata[51:30], va_r[29:0]};
      RES_2M: res_pa = {12'b0, rdata[51:21], va_r[20:0]};
      RES_4K: res_pa = {12'b0, rdata[51:12], va_r[11:0]};
      default: res_pa = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_pa_r    <= res_pa;
      res_fault_r <= res_fault;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pa_r    <= res_pa_r;
      out_fault_r <= res_fault_r;
    end
  end

  assign out_physical_address = out_pa_r;
  assign out_fault            = out_fault_r;

  assign status.op       = op_r;
  assign status.present  = rdata[BIT_PRESENT];
  assign status.huge     = rdata[BIT_HUGE];
  assign status.clr_last = &clr_cnt_r;

endmodule

// ----- hdl/four_level_page_walker_core.sv -----
// Channel   Dir  Handshake      Payload
// in_chan   in   valid/ready    op, virtual_address, word_index, word_value
// out_chan  out  valid/ready    physical_address, fault
// cfg_chan  in   valid/ready    root_table_address
//
// After reset the table store is swept to zero, one word a cycle, all 4096
// words (TABLE_WORDS); no item is accepted meanwhile, configuration is.
// One item at a time: a translate or unmap makes one dependent read of the
// single store read port for each table entry it looks at; a write or an
// ignored op makes none. A stalled result holds only its output register;
// the next item is accepted while it waits.
module four_level_page_walker_core
  import fpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fpw_in_if.sink      in_chan,
  fpw_out_if.source   out_chan,
  fpw_cfg_if.sink     cfg_chan
);

  cmd_t    cmd;
  status_t status;
  state_t  state;

  // Configuration is always taken.
  assign cfg_chan.ready = 1'b1;

  fpw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .status    (status),
    .cmd       (cmd),
    .state     (state)
  );

  fpw_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .status                 (status),
    .in_op                  (in_chan.op),
    .in_virtual_address     (in_chan.virtual_address),
    .in_word_index          (in_chan.word_index),
    .in_word_value          (in_chan.word_value),
    .cfg_we                 (cfg_chan.valid),
    .cfg_root_table_address (cfg_chan.root_table_address),
    .out_physical_address   (out_chan.physical_address),
    .out_fault              (out_chan.fault)
  );

  // An accepted transaction is dispatched in the next cycle.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> state == ST_DISPATCH)
    else $error("accepted transaction not dispatched");

  // Walk states only write the store for an unmap.
  a_walk_write_unmap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr && (state == ST_CK3 || state == ST_CK2) |-> status.op == OP_UNMAP)
    else $error("store written during a translate walk");

  // A new result appears only after a load of the output register.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.load_out))
    else $error("result shown without a load");

  // No transaction is taken during the clearing sweep.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state == ST_CLEAR |-> !cmd.latch_in && !out_chan.valid)
    else $error("activity during clearing sweep");

endmodule

// ----- verif/four_level_page_walker_core_test.sv -----
module four_level_page_walker_core_test;
  import fpw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Entry fields and offsets of the x86-64 style page table.
  localparam logic [63:0] ADDR_4K  = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] ADDR_2M  = 64'h000F_FFFF_FFE0_0000;
  localparam logic [63:0] ADDR_1G  = 64'h000F_FFFF_C000_0000;
  localparam logic [63:0] OFS_4K   = 64'h0000_0000_0000_0FFF;
  localparam logic [63:0] OFS_2M   = 64'h0000_0000_001F_FFFF;
  localparam logic [63:0] OFS_1G   = 64'h0000_0000_3FFF_FFFF;
  localparam logic [63:0] VPN_MASK = 64'h1FF;
  localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

  localparam int DRAIN_CYCLES  = 12;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 300;
  localparam int TIMEOUT_NS    = 2_000_000;

  typedef struct packed {
    logic [PA_W-1:0] pa;
    logic            fault;
  } walk_result_t;

  localparam walk_result_t FAULT_RESULT = '{pa: '1, fault: 1'b1};

  logic clk = 1'b0;
  logic rst_n;

  fpw_in_if  in_if();
  fpw_out_if out_if();
  fpw_cfg_if cfg_if();

  four_level_page_walker_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Shadow copy of the block state.
  logic [WORD_W-1:0] page_store [TABLE_WORDS];
  logic [ROOT_W-1:0] root_addr;

  walk_result_t pending_results[$];
  int unsigned  mismatches;
  int unsigned  items_sent;
  int unsigned  hold_cycles;
  bit           quiet_source;
  bit           quiet_sink;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Store word holding the entry for one level of a virtual address.
  function automatic logic [IDX_W-1:0] entry_slot(logic [63:0] table_addr,
                                                  logic [63:0] va, int shift);
    logic [63:0] words;
    words = (((table_addr & ADDR_4K) >> 3) + ((va >> shift) & VPN_MASK)) % TABLE_WORDS;
    return words[IDX_W-1:0];
  endfunction

  // Applies one transaction to the shadow store and returns its result.
  function automatic walk_result_t walk_table(op_t op, logic [VA_W-1:0] va,
                                              logic [WIDX_W-1:0] widx,
                                              logic [WORD_W-1:0] wval);
    walk_result_t     res;
    logic [IDX_W-1:0] s4, s3, s2, s1;
    logic [WORD_W-1:0] e4, e3, e2;
    res = '{pa: '0, fault: 1'b0};
    if (op == OP_WRITE) begin
      page_store[widx % TABLE_WORDS] = wval;
      return res;
    end
    if (op == OP_NONE) return res;

    s4 = entry_slot(64'(root_addr), va, SHIFT_L4);
    e4 = page_store[s4];
    if (!e4[BIT_PRESENT]) return FAULT_RESULT;

    s3 = entry_slot(e4, va, SHIFT_L3);
    e3 = page_store[s3];
    if (!e3[BIT_PRESENT]) return FAULT_RESULT;
    if (e3[BIT_HUGE]) begin
      if (op == OP_TRANSLATE) res.pa = (e3 & ADDR_1G) | (va & OFS_1G);
      else page_store[s3] = '0;
      return res;
    end

    s2 = entry_slot(e3, va, SHIFT_L2);
    e2 = page_store[s2];
    if (!e2[BIT_PRESENT]) return FAULT_RESULT;
    if (e2[BIT_HUGE]) begin
      if (op == OP_TRANSLATE) res.pa = (e2 & ADDR_2M) | (va & OFS_2M);
      else page_store[s2] = '0;
      return res;
    end

    // The last level is cleared on unmap without looking at its present bit.
    s1 = entry_slot(e2, va, SHIFT_L1);
    if (op == OP_UNMAP) begin
      page_store[s1] = '0;
      return res;
    end
    if (!page_store[s1][BIT_PRESENT]) return FAULT_RESULT;
    res.pa = (page_store[s1] & ADDR_4K) | (va & OFS_4K);
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Builds a table entry; the other attribute bits come from noise.
  function automatic logic [63:0] make_entry(logic [39:0] frame, bit present, bit huge,
                                             logic [63:0] noise);
    return {noise[63:52], frame, noise[11:8], huge, noise[6:1], present};
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Drives one input transaction and records its predicted result.
  task automatic send_item(op_t op, logic [VA_W-1:0] va, logic [WIDX_W-1:0] widx,
                           logic [WORD_W-1:0] wval);
    int unsigned gap;
    gap = quiet_source ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.op              <= op;
    in_if.virtual_address <= va;
    in_if.word_index      <= widx;
    in_if.word_value      <= wval;
    in_if.valid           <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(walk_table(op, va, widx, wval));
    items_sent++;
  endtask

  task automatic write_word(logic [WIDX_W-1:0] widx, logic [WORD_W-1:0] wval);
    send_item(OP_WRITE, rand64(), widx, wval);
  endtask

  // Waits until every outstanding result is back and the walker has gone quiet.
  task automatic drain();
    int n;
    n = 0;
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_root(logic [ROOT_W-1:0] value);
    @(negedge clk);
    cfg_if.root_table_address <= value;
    cfg_if.valid              <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    root_addr = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Result side: random back-pressure between transactions.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    walk_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_if.physical_address, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.physical_address !== want.pa)
          report_mismatch("physical_address", out_if.physical_address, want.pa);
        if (out_if.fault !== want.fault)
          report_mismatch("fault", 64'(out_if.fault), 64'(want.fault));
      end
      hold_cycles = quiet_sink ? 0 : $urandom_range(0, 16);
    end
  end

  // An empty store faults every walk; the unused op returns zero.
  task automatic test_empty_store();
    write_root(ROOT_MAX);
    send_item(OP_TRANSLATE, 64'h0, '0, '0);
    send_item(OP_UNMAP, 64'h0, '0, '0);
    send_item(OP_NONE, '1, '1, '1);
    send_item(OP_TRANSLATE, '1, '0, '0);
  endtask

  // With the root in the last frame and all-ones addresses, the top entry is
  // also the PDPT entry, so its ignored huge bit turns into a 1GB page.
  task automatic test_top_entry_reuse();
    write_word('1, '1);
    send_item(OP_TRANSLATE, '1, '0, '0);
    send_item(OP_UNMAP, '1, '0, '0);
    send_item(OP_TRANSLATE, '1, '0, '0);
  endtask

  // Full walk to a 4KB page, then a missing leaf, then a 2MB page and its removal.
  task automatic test_leaf_and_huge_walks();
    logic [63:0] va;
    va = 64'h0000_0000_0000_0ABC;
    write_word(12'd3584, make_entry(40'h1, 1'b1, 1'b0, '0));
    write_word(12'd512, make_entry(40'h2, 1'b1, 1'b0, '0));
    write_word(12'd1024, make_entry(40'h3, 1'b1, 1'b0, '0));
    write_word(12'd1536, '1);
    send_item(OP_TRANSLATE, va, '0, '0);
    write_word(12'd1536, '0);
    send_item(OP_TRANSLATE, va, '0, '0);
    // Unmap of a leaf that is not present still succeeds.
    send_item(OP_UNMAP, va, '0, '0);
    write_word(12'd1024, make_entry(40'hFF_FFFF_F003, 1'b1, 1'b1, '1));
    send_item(OP_TRANSLATE, 64'h0000_0000_001F_FFFF, '0, '0);
    send_item(OP_UNMAP, 64'h0000_0000_001F_FFFF, '0, '0);
    send_item(OP_TRANSLATE, 64'h0000_0000_001F_FFFF, '0, '0);
    // The directory entry is gone, so a second unmap faults.
    send_item(OP_UNMAP, 64'h0000_0000_001F_FFFF, '0, '0);
  endtask

  // Table addresses far above the store wrap back into it.
  task automatic test_store_wrap();
    drain();
    write_root('0);
    write_word('0, make_entry(40'hFF_FFFF_FFF8, 1'b1, 1'b0, 64'hABCD_0000_0000_0F00));
    send_item(OP_TRANSLATE, 64'h0, '0, '0);
  endtask

  // One random mapping chain followed by walks over it, or a burst of noise.
  task automatic random_walk_round();
    logic [63:0] va, probe, e4, e3, e2;
    logic [IDX_W-1:0] s3, s2, s1;
    int n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) send_item(op_t'(2'($urandom_range(0, 3))), rand64(), 12'($urandom),
                           rand64());
      return;
    end
    va = rand64();
    e4 = make_entry({$urandom, 8'($urandom)}, $urandom_range(0, 15) != 0,
                    $urandom_range(0, 7) == 0, rand64());
    e3 = make_entry({$urandom, 8'($urandom)}, $urandom_range(0, 15) != 0,
                    $urandom_range(0, 5) == 0, rand64());
    e2 = make_entry({$urandom, 8'($urandom)}, $urandom_range(0, 15) != 0,
                    $urandom_range(0, 5) == 0, rand64());
    s3 = entry_slot(e4, va, SHIFT_L3);
    s2 = entry_slot(e3, va, SHIFT_L2);
    s1 = entry_slot(e2, va, SHIFT_L1);
    if ($urandom_range(0, 7) != 0) write_word(entry_slot(64'(root_addr), va, SHIFT_L4), e4);
    if ($urandom_range(0, 7) != 0) write_word(s3, e3);
    if ($urandom_range(0, 7) != 0) write_word(s2, e2);
    if ($urandom_range(0, 7) != 0)
      write_word(s1, make_entry({$urandom, 8'($urandom)}, $urandom_range(0, 15) != 0,
                                1'($urandom_range(0, 1)), rand64()));
    n = $urandom_range(1, 4);
    repeat (n) begin
      probe = va;
      probe[63:48] = 16'($urandom);
      probe[11:0]  = 12'($urandom);
      if ($urandom_range(0, 3) == 0) probe[29:12] = 18'($urandom);
      send_item($urandom_range(0, 3) == 0 ? OP_UNMAP : OP_TRANSLATE, probe,
                12'($urandom), rand64());
    end
  endtask

  // Random phases under several root table settings, extremes included.
  task automatic test_random_walks();
    logic [ROOT_W-1:0] roots [5];
    int unsigned target;
    roots[0] = ROOT_MAX;
    roots[1] = '0;
    for (int i = 2; i < 5; i++) roots[i] = ROOT_W'(rand64());
    foreach (roots[p]) begin
      drain();
      write_root(roots[p]);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 7) == 0) quiet_source = !quiet_source;
        if ($urandom_range(0, 7) == 0) quiet_sink = !quiet_sink;
        random_walk_round();
      end
    end
  endtask

  initial begin
    rst_n                     = 1'b0;
    in_if.valid               = 1'b0;
    in_if.op                  = '0;
    in_if.virtual_address     = '0;
    in_if.word_index          = '0;
    in_if.word_value          = '0;
    out_if.ready              = 1'b0;
    cfg_if.valid              = 1'b0;
    cfg_if.root_table_address = '0;
    foreach (page_store[i]) page_store[i] = '0;
    root_addr    = '0;
    mismatches   = 0;
    items_sent   = 0;
    hold_cycles  = 0;
    quiet_source = 1'b0;
    quiet_sink   = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_store();
    test_top_entry_reuse();
    test_leaf_and_huge_walks();
    test_store_wrap();
    test_random_walks();

    drain();
    if (pending_results.size() != 0)
      report_mismatch("results never returned", 64'(pending_results.size()), '0);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #TIMEOUT_NS;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
